// ----- hdl/sorted_key_set_insert_query_macros.svh -----
// Assertion macros shared by the sorted key set RTL.
`ifndef SORTED_KEY_SET_INSERT_QUERY_MACROS_SVH
`define SORTED_KEY_SET_INSERT_QUERY_MACROS_SVH

`ifndef SYNTH

`define SKSI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SKSI_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `SKSI_ASSERT(label, clk, rst_n, !(cond), msg)

`else

`define SKSI_ASSERT(label, clk, rst_n, prop, msg)

`define SKSI_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- hdl/sksi_pkg.sv -----
// Package with the constants and transfer types of the sorted key set.
package sksi_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 16;
    localparam int COUNT_FIELD_W = 9;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic                     hit;
        logic                     inserted;
        logic                     full_res;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } rsp_t;

endpackage

// ----- hdl/sksi_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module sksi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/sorted_key_set_insert_query.sv -----
// Top level of the sorted key set: search, shift and insert around one key RAM.
//
// The keys are held in ascending order in a single RAM of CAPACITY entries with a
// registered read. Every request is searched by a binary search in which each step
// sends the middle address out and then compares the returned key. An insert of a
// new key then moves every larger key up by one place, one entry per cycle through
// the RAM's read and write ports, and writes the new key. One request is worked on
// at a time; a new request is taken as soon as the previous result is in the output
// register, even while that result waits.
`include "sorted_key_set_insert_query_macros.svh"

module sorted_key_set_insert_query
    import sksi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_SHIFT,
        ST_WKEY,
        ST_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic               func_reg, func_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [CNT_W-1:0]   src_reg, src_next;
    logic [ADDR_W-1:0]  wa_reg, wa_next;
    logic               pend_reg, pend_next;
    logic               hit_reg, hit_next;
    logic               ins_reg, ins_next;
    logic               full_reg, full_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [CNT_W-1:0]   mid;
    logic [CNT_W-1:0]   src_dec;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [KEY_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [KEY_W-1:0]   ram_rdata;

    sksi_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_key_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign src_dec = src_reg - CNT_W'(1);

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        src_next       = src_reg;
        wa_next        = wa_reg;
        pend_next      = pend_reg;
        hit_next       = hit_reg;
        ins_next       = ins_reg;
        full_next      = full_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = wa_reg;
        ram_wdata      = key_reg;
        ram_re         = 1'b0;
        ram_raddr      = mid[ADDR_W-1:0];

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req.func;
                    key_next   = req.key;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    hit_next   = 1'b0;
                    ins_next   = 1'b0;
                    full_next  = 1'b0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = mid[ADDR_W-1:0];
                    mid_next   = mid;
                    state_next = ST_COMPARE;
                end
                else if (func_reg == FUNC_INSERT && !hit_reg)
                begin
                    if (count_reg == CNT_W'(CAPACITY))
                    begin
                        full_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        src_next   = count_reg;
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COMPARE:
            begin
                if (ram_rdata < key_reg)
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                if (ram_rdata == key_reg)
                begin
                    hit_next = 1'b1;
                end
                state_next = ST_SEARCH;
            end
            ST_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (src_reg != lo_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = src_dec[ADDR_W-1:0];
                    wa_next   = src_reg[ADDR_W-1:0];
                    src_next  = src_dec;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = ST_WKEY;
                end
            end
            ST_WKEY:
            begin
                ram_we     = 1'b1;
                ram_waddr  = lo_reg[ADDR_W-1:0];
                ram_wdata  = key_reg;
                count_next = count_reg + CNT_W'(1);
                ins_next   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.hit         = hit_reg;
                    rsp_next.inserted    = ins_reg;
                    rsp_next.full_res    = full_reg;
                    rsp_next.entry_count = COUNT_FIELD_W'(count_reg);
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= FUNC_INSERT;
            key_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            src_reg       <= '0;
            wa_reg        <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            ins_reg       <= 1'b0;
            full_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            key_reg       <= key_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            src_reg       <= src_next;
            wa_reg        <= wa_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            ins_reg       <= ins_next;
            full_reg      <= full_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // The count never passes the capacity of the key RAM.
    `SKSI_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(CAPACITY), "count over capacity")

    // A shifted key is never written to the entry being read in the same cycle.
    `SKSI_ASSERT_NEVER(a_ram_collision, clk, rst_n, ram_we && ram_re && ram_waddr == ram_raddr, "RAM read and write collide")

    // Writing the new key grows the set by exactly one.
    `SKSI_ASSERT(a_count_step, clk, rst_n, state_reg == ST_WKEY |=> count_reg == $past(count_reg) + CNT_W'(1), "count did not step")

    // A result never reports both a hit and an insert, nor an insert and a refusal.
    `SKSI_ASSERT_NEVER(a_rsp_flags, clk, rst_n, rsp_valid_reg && ((rsp_reg.hit && rsp_reg.inserted) || (rsp_reg.inserted && rsp_reg.full_res)), "inconsistent result flags")

endmodule
